// ----- sv/lgs_pkg.sv -----
// Shared types, constants and the Life rule for the generation stencil.
// No dependencies; every other file of the block but lgs_line_store imports this package.
package lgs_pkg;

	// Default grid limits
	localparam int LGS_MAX_COLS = 1024;
	localparam int LGS_MAX_ROWS = 1024;

	// Smallest grid dimension accepted by the registers
	localparam int GRID_MIN = 3;

	// Field widths
	localparam int CFG_W     = 11;
	localparam int ROW_W     = 11;
	localparam int OUT_POS_W = 10;

	// Register indexes
	localparam logic [0:0] REG_GRID_COLS = 1'd0;
	localparam logic [0:0] REG_GRID_ROWS = 1'd1;

	// One result item
	typedef struct packed {
		logic                 next_alive;
		logic [OUT_POS_W-1:0] out_row;
		logic [OUT_POS_W-1:0] out_col;
		logic                 last_cell;
	} res_t;

	// Next state of the centre of a 3x3 window (column k in bits 3k..3k+2)
	function automatic logic life_next(input logic [8:0] w);
		logic [3:0] n;
		n = 4'd0;
		for (int b = 0; b < 9; b++) begin
			if (b != 4) begin
				n = n + {3'd0, w[b]};
			end
		end
		return (n == 4'd3) || ((n == 4'd2) && w[4]);
	endfunction

endpackage

// ----- sv/life_generation_stencil_unit.sv -----
// Top level of the Life generation stencil (B3/S23, dead border).
// Depends on lgs_pkg, lgs_stencil and lgs_out_skid.
//
// Usage: cells of the current generation enter on the slave stream in
// row-major order, one item each; s_tdata[0] is the cell, s_tuser marks a
// flush item. After the last cell send grid_cols+1 flush items to drain
// the bottom row. Each result on the master stream carries the next state
// of one cell with its row and column; m_tlast marks the final cell.
// A result is registered in the output register, or in the skid stage
// while the receiver stalls, at the edge its causing item is accepted;
// results trail the input by grid_cols+1 items. Throughput is one item a
// cycle while s_tready is high, set by the single read and write port of
// the line store, whose next column is prefetched on every accepted item.
// Reset clears position, window and count and sets a 1024 x 1024 grid;
// a register write restarts the frame. When the receiver stalls, one
// further result goes into the skid stage; s_tready then drops until the
// receiver takes the item waiting in the output register.
module life_generation_stencil_unit
	import lgs_pkg::*;
#(
	parameter int MAX_COLS = LGS_MAX_COLS,
	parameter int MAX_ROWS = LGS_MAX_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // [0] cell_alive, [7:1] zero
	input  logic             s_tuser,  // [0] flush
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,  // [0] next_alive, [10:1] out_row, [20:11] out_col
	output logic             m_tlast
);

	logic res_valid;
	res_t res;
	res_t m_res;

	lgs_stencil #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cell_alive (s_tdata[0]),
		.flush      (s_tuser),
		.res_valid  (res_valid),
		.res        (res)
	);

	lgs_out_skid u_out_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_ready (s_tready),
		.push_res   (res),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.m_res      (m_res)
	);

	// Pack the result item
	assign m_tdata = {3'd0, m_res.out_col, m_res.out_row, m_res.next_alive};
	assign m_tlast = m_res.last_cell;

	// The skid stage only fills behind a full output register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("skid stage full with empty output register");

	// A full skid stage stays full while the receiver stalls
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready && !m_tready) |=> !s_tready)
		else $error("skid stage drained during a stall");

	// The final cell lies at least on the third row
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last_cell) |-> (res.out_row >= OUT_POS_W'(2)))
		else $error("final cell on an impossible row");

endmodule

// ----- sv/lgs_line_store.sv -----
// Line store of the stencil: two bits a column, one write and one read port.
// Read data is registered. Depends on nothing.
module lgs_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem [DEPTH];

	// Write the column just seen
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Fetch the entry of the next column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/lgs_out_skid.sv -----
// Output register with a skid stage for the result items.
// Depends on lgs_pkg for the result type.
module lgs_out_skid
	import lgs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  res_t push_res,
	output logic m_valid,
	input  logic m_ready,
	output res_t m_res
);

	logic main_v_q;
	logic spare_v_q;
	res_t main_q;
	res_t spare_q;
	logic pop;

	assign pop        = main_v_q & m_ready;
	assign push_ready = ~spare_v_q;
	assign m_valid    = main_v_q;
	assign m_res      = main_q;

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q  <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (spare_v_q) begin
			if (pop) begin
				spare_v_q <= 1'b0;
			end
		end else if (!main_v_q || pop) begin
			main_v_q <= push;
		end else if (push) begin
			spare_v_q <= 1'b1;
		end
	end

	// Move payload: spare drains into main first
	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (pop) begin
				main_q <= spare_q;
			end
		end else if (!main_v_q || pop) begin
			main_q <= push_res;
		end else if (push) begin
			spare_q <= push_res;
		end
	end

endmodule

// ----- sv/lgs_stencil.sv -----
// Stencil datapath: position counters, 3x3 window, grid registers and the
// Life rule. Depends on lgs_pkg and lgs_line_store.
module lgs_stencil
	import lgs_pkg::*;
#(
	parameter int MAX_COLS = LGS_MAX_COLS,
	parameter int MAX_ROWS = LGS_MAX_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             cell_alive,
	input  logic             flush,
	output logic             res_valid,
	output res_t             res
);

	localparam int CIDX     = $clog2(MAX_COLS);
	localparam int GCW      = $clog2(MAX_COLS + 1);
	localparam int GRW      = $clog2(MAX_ROWS + 1);
	localparam int TOTW     = GCW + GRW;
	localparam int RST_COLS = (1024 > MAX_COLS) ? MAX_COLS : 1024;
	localparam int RST_ROWS = (1024 > MAX_ROWS) ? MAX_ROWS : 1024;

	logic [GCW-1:0]   grid_cols_q;
	logic [GRW-1:0]   grid_rows_q;
	logic [TOTW-1:0]  total_q;
	logic [CIDX-1:0]  in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [TOTW-1:0]  emit_count_q;
	logic [8:0]       window_q;

	logic [GCW-1:0]   cols_new;
	logic [GRW-1:0]   rows_new;
	logic             accept;
	logic [1:0]       stored;
	logic             cur, above1, above2;
	logic [2:0]       newcol;
	logic [8:0]       window_n, view;
	logic             candidate;
	logic [OUT_POS_W-1:0] er, ec;
	logic             col_wrap;
	logic [CIDX-1:0]  in_col_n;
	logic [ROW_W-1:0] in_row_n;
	logic [TOTW-1:0]  emit_inc;
	logic             last;

	assign accept = in_valid & in_ready;

	// Clamp register writes to the supported range
	always_comb begin
		if (32'(cfg_data) < 32'(GRID_MIN)) begin
			cols_new = GCW'(GRID_MIN);
			rows_new = GRW'(GRID_MIN);
		end else begin
			cols_new = (32'(cfg_data) > 32'(MAX_COLS)) ? GCW'(MAX_COLS) : GCW'(cfg_data);
			rows_new = (32'(cfg_data) > 32'(MAX_ROWS)) ? GRW'(MAX_ROWS) : GRW'(cfg_data);
		end
	end

	// Neighbourhood of the incoming cell
	always_comb begin
		cur    = (flush || (32'(in_row_q) >= 32'(grid_rows_q))) ? 1'b0 : cell_alive;
		above1 = (in_row_q >= ROW_W'(1)) ? stored[0] : 1'b0;
		above2 = (in_row_q >= ROW_W'(2)) ? stored[1] : 1'b0;
		newcol = {cur, above1, above2};
		if (in_col_q == '0) begin
			view      = {3'd0, window_q[8:3]};
			window_n  = {newcol, 6'd0};
			candidate = (in_row_q >= ROW_W'(2));
			er        = OUT_POS_W'(32'(in_row_q) - 32'd2);
			ec        = OUT_POS_W'(32'(grid_cols_q) - 32'd1);
		end else begin
			window_n  = {newcol, window_q[8:3]};
			view      = window_n;
			candidate = (in_row_q >= ROW_W'(1));
			er        = OUT_POS_W'(32'(in_row_q) - 32'd1);
			ec        = OUT_POS_W'(32'(in_col_q) - 32'd1);
		end
	end

	// Next input position
	always_comb begin
		col_wrap = (32'(in_col_q) + 32'd1) >= 32'(grid_cols_q);
		in_col_n = col_wrap ? '0 : CIDX'(32'(in_col_q) + 32'd1);
		in_row_n = in_row_q;
		if (col_wrap && (in_row_q != '1)) begin
			in_row_n = in_row_q + ROW_W'(1);
		end
	end

	// Result of this item
	assign emit_inc       = emit_count_q + TOTW'(1);
	assign last           = (emit_inc == total_q);
	assign res_valid      = accept & candidate & (emit_count_q < total_q);
	assign res.next_alive = life_next(view);
	assign res.out_row    = er;
	assign res.out_col    = ec;
	assign res.last_cell  = last;

	// Hold the grid size and the cell count of a generation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GCW'(RST_COLS);
			grid_rows_q <= GRW'(RST_ROWS);
			total_q     <= TOTW'(RST_COLS * RST_ROWS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_COLS: begin
					grid_cols_q <= cols_new;
					total_q     <= TOTW'(cols_new) * TOTW'(grid_rows_q);
				end
				REG_GRID_ROWS: begin
					grid_rows_q <= rows_new;
					total_q     <= TOTW'(grid_cols_q) * TOTW'(rows_new);
				end
				default: begin
				end
			endcase
		end
	end

	// Advance position, window and count; restart on a write or at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			emit_count_q <= '0;
			window_q     <= '0;
		end else if (cfg_we) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			emit_count_q <= '0;
			window_q     <= '0;
		end else if (accept) begin
			if (res_valid && last) begin
				in_col_q     <= '0;
				in_row_q     <= '0;
				emit_count_q <= '0;
				window_q     <= '0;
			end else begin
				in_col_q <= in_col_n;
				in_row_q <= in_row_n;
				window_q <= window_n;
				if (res_valid) begin
					emit_count_q <= emit_inc;
				end
			end
		end
	end

	// Store this column and prefetch the next; after a restart row zero masks it
	lgs_line_store #(
		.DEPTH (MAX_COLS),
		.AW    (CIDX)
	) u_line_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (in_col_q),
		.wr_data ({above1, cur}),
		.rd_en   (accept),
		.rd_addr (in_col_n),
		.rd_data (stored)
	);

endmodule

// ----- tb/tb_life_sb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the Life generation stencil: its own next-generation predictor and result queue.
// Depends on lgs_pkg for the result layout, grid limits and register indexes.
package tb_life_sb_pkg;
	import lgs_pkg::*;

	class life_gen_scoreboard;
		// Predictor state: two rows of history per column, 3x3 window, position, count
		bit [1:0]    hist_cols [LGS_MAX_COLS];
		bit [8:0]    nbhd;
		int unsigned at_row, at_col, emitted;
		int unsigned cols, rows;
		res_t        due_cells [$];
		int unsigned fails, checked, cells_noted, generations;

		function new();
			foreach (hist_cols[i]) hist_cols[i] = 2'b00;
			cols = LGS_MAX_COLS;
			rows = LGS_MAX_ROWS;
			fails = 0;
			checked = 0;
			cells_noted = 0;
			generations = 0;
			restart();
		endfunction

		function void restart();
			nbhd = 9'd0;
			at_row = 0;
			at_col = 0;
			emitted = 0;
		endfunction

		function int pending();
			return due_cells.size();
		endfunction

		// B3/S23 on the centre of a window, column k in bits 3k..3k+2
		function bit next_state(bit [8:0] view);
			int unsigned around;
			around = $countones(view & 9'h1EF);
			return (around == 3) || (around == 2 && view[4]);
		endfunction

		// Clamp the register to its legal range; any write starts a fresh frame
		function void set_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
			int unsigned v;
			v = val;
			if (v < GRID_MIN) v = GRID_MIN;
			case (idx)
				REG_GRID_COLS: cols = (v > LGS_MAX_COLS) ? LGS_MAX_COLS : v;
				REG_GRID_ROWS: rows = (v > LGS_MAX_ROWS) ? LGS_MAX_ROWS : v;
				default: ;
			endcase
			restart();
		endfunction

		// Advance the stencil by one accepted item and queue the cell it completes
		function void note_cell(bit alive, bit pad);
			bit          cur, above1, above2, hit;
			bit [2:0]    col_bits;
			bit [8:0]    view;
			int unsigned c, er, ec, total;
			res_t        r;
			cells_noted++;
			c = (at_col >= LGS_MAX_COLS) ? LGS_MAX_COLS - 1 : at_col;
			// padding and anything below the grid count as dead
			cur = alive && !pad && (at_row < rows);
			above1 = (at_row >= 1) ? hist_cols[c][0] : 1'b0;
			above2 = (at_row >= 2) ? hist_cols[c][1] : 1'b0;
			col_bits = {cur, above1, above2};
			hist_cols[c] = {above1, cur};
			hit = 1'b0;
			er = 0;
			ec = 0;
			if (c == 0) begin
				// close the last column of the row two above against a dead right edge
				view = {3'b000, nbhd[8:3]};
				if (at_row >= 2) begin
					hit = 1'b1;
					er = at_row - 2;
					ec = cols - 1;
				end
				nbhd = {col_bits, 6'd0};
			end else begin
				nbhd = {col_bits, nbhd[8:3]};
				view = nbhd;
				if (at_row >= 1) begin
					hit = 1'b1;
					er = at_row - 1;
					ec = c - 1;
				end
			end
			at_col = c + 1;
			if (at_col >= cols) begin
				at_col = 0;
				if (at_row < 11'h7FF) at_row++;
			end
			total = rows * cols;
			if (hit && emitted < total) begin
				emitted++;
				r.next_alive = next_state(view);
				r.out_row = er[OUT_POS_W-1:0];
				r.out_col = ec[OUT_POS_W-1:0];
				r.last_cell = (emitted == total);
				due_cells.push_back(r);
				if (emitted == total) restart();
			end
		endfunction

		// Print one line and count; hold the log short once a design is clearly broken
		task report_mismatch(string msg);
			fails++;
			if (fails <= 40) $display("[%0t] error: %s", $time, msg);
		endtask

		// Compare one accepted result against the oldest queued cell
		task check_result(logic [23:0] data, logic last);
			res_t want;
			checked++;
			if (due_cells.size() == 0) begin
				report_mismatch($sformatf("result row %0d col %0d with no cell due",
					data[10:1], data[20:11]));
				return;
			end
			want = due_cells.pop_front();
			if (data[0] !== want.next_alive)
				report_mismatch($sformatf("cell %0d,%0d: next state %b, want %b",
					want.out_row, want.out_col, data[0], want.next_alive));
			if (data[10:1] !== want.out_row)
				report_mismatch($sformatf("row %0d, want %0d", data[10:1], want.out_row));
			if (data[20:11] !== want.out_col)
				report_mismatch($sformatf("col %0d, want %0d", data[20:11], want.out_col));
			if (last !== want.last_cell)
				report_mismatch($sformatf("cell %0d,%0d: tlast %b, want %b",
					want.out_row, want.out_col, last, want.last_cell));
			if (want.last_cell) generations++;
		endtask
	endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level bench for life_generation_stencil_unit: drives cell streams and register writes.
// Depends on lgs_pkg, tb_life_sb_pkg and the block's RTL.
module tb_top;
	import lgs_pkg::*;
	import tb_life_sb_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [0:0]       cfg_index = REG_GRID_COLS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = 8'd0;   // [0] cell_alive, [7:1] zero
	logic             s_tuser = 1'b0;   // [0] flush
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;          // [0] next_alive, [10:1] out_row, [20:11] out_col
	logic             m_tlast;

	int unsigned src_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned items_sent = 0;
	life_gen_scoreboard gen_sb;

	life_generation_stencil_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Stall the result stream at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Observe writes and handshakes on the edge they complete
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) gen_sb.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) gen_sb.note_cell(s_tdata[0], s_tuser);
			if (m_tvalid && m_tready) gen_sb.check_result(m_tdata, m_tlast);
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("stalled for %0d cycles with %0d results outstanding",
			QUIET_LIMIT, gen_sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(input bit alive, input bit pad);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, alive};
		s_tuser <= pad;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every queued cell has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (gen_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pattern(input bit [31:0] alive, input bit [31:0] pad, input int n);
		for (int i = 0; i < n; i++) send_item(alive[i], pad[i]);
	endtask

	// One frame of random cells, then the drain; a partial frame stops early and has no drain
	task automatic run_frame(input bit whole);
		int unsigned n, density;
		n = gen_sb.cols * gen_sb.rows;
		if (!whole) n = $urandom_range(n - 1, 1);
		density = $urandom_range(60, 15);
		for (int unsigned i = 0; i < n; i++)
			send_item($urandom_range(99) < density, $urandom_range(99) < 4);
		if (whole) begin
			for (int unsigned i = 0; i <= gen_sb.cols; i++)
				send_item($urandom_range(1), $urandom_range(1));
		end
	endtask

	initial begin
		int unsigned mark;
		gen_sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Vertical blinker on a clamped 3x3 grid; live cells in the drain must read as dead
		write_reg(REG_GRID_COLS, 2);
		write_reg(REG_GRID_ROWS, 0);
		send_pattern(32'h1E92, 32'h0A00, 13);
		settle();

		// Full 4x3 grid with one padding item inside the frame
		write_reg(REG_GRID_COLS, 4);
		send_pattern(32'h1FFFF, 32'h15020, 17);
		settle();

		// Random frames under each pacing mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_gap_pct = 74; sink_stall_pct = 0;  end
				2: begin src_gap_pct = 0;  sink_stall_pct = 74; end
				default: begin src_gap_pct = 22; sink_stall_pct = 22; end
			endcase
			mark = items_sent;
			while (items_sent - mark < 110) begin
				settle();
				write_reg(REG_GRID_COLS,
					($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(12, 3));
				write_reg(REG_GRID_ROWS,
					($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(10, 3));
				repeat ($urandom_range(2, 1)) run_frame(1'b1);
				// abandon a frame part-way; the next write restarts it
				if ($urandom_range(4) == 0) run_frame(1'b0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("%0d items in, %0d results checked, %0d complete generations",
			gen_sb.cells_noted, gen_sb.checked, gen_sb.generations);
		$display("grids from clamped 3x3 to 12 x 10, whole and abandoned frames, four pacing mixes");
		if (gen_sb.fails == 0 && gen_sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
